// ===== rtl/pkwrl_pkg.sv =====
// package for the per-key window rate limiter
// types, register indexes, outcome codes and sizes; no dependencies
`timescale 1ns / 1ps

package pkwrl_pkg;

    localparam int unsigned KEY_W         = 64;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned LIMIT_W       = 10;
    localparam int unsigned WINDOW_W      = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned TABLE_ENTRIES_DEFAULT = 128;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 10'd60;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

    typedef enum logic [2:0] {
        OUT_DISABLED = 3'd0,
        OUT_COUNTED  = 3'd1,
        OUT_OVER     = 3'd2,
        OUT_RESTART  = 3'd3,
        OUT_NEW      = 3'd4,
        OUT_FULL     = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [KEY_W-1:0]  user_key;
        logic [TIME_W-1:0] current_time;
    } in_t;

    typedef struct packed {
        logic     allowed;
        outcome_t outcome;
    } out_t;

    typedef struct packed {
        in_t  item;
        logic disabled;
    } job_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  window_start;
        logic [LIMIT_W-1:0] count;
    } entry_t;

endpackage

// ===== rtl/per_key_window_rate_limiter_top.sv =====
// top level of the per-key window rate limiter: config registers, front, back
// depends on pkwrl_pkg, pkwrl_front, pkwrl_back
`timescale 1ns / 1ps

// usage
// requests enter on in_valid/in_ready/in_data (user key, time in seconds),
// one decision beat per request leaves on out_valid/out_ready/out_data
// (allowed flag and outcome code), in request order.
// a two-deep queue takes requests while the table engine works on an older one.
// the engine scans the key table, one entry per cycle from a registered-read ram;
// a hit passes through the scan, hit and emit states, a miss through scan and emit,
// with at most TABLE_ENTRIES entries scanned;
// a disabled limiter or an empty table skips the scan and goes straight to emit.
// the engine finishes one request before it takes the next one from the queue.
// cfg_we with cfg_index 0 writes limit_per_window, index 1 writes window_seconds;
// write only while no request is in flight.
// reset empties the table and the queue and loads limit 60, window 60 s.
// a stalled receiver holds the output beat; the engine then waits with its next
// decision and the queue fills, dropping in_ready when full.
module per_key_window_rate_limiter_top #(
    parameter int unsigned TABLE_ENTRIES = pkwrl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pkwrl_pkg::in_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pkwrl_pkg::out_t                   out_data,
    input  logic                              cfg_we,
    input  logic [pkwrl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pkwrl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [pkwrl_pkg::LIMIT_W-1:0]  limit_reg;
    logic [pkwrl_pkg::WINDOW_W-1:0] window_reg;
    logic                           job_valid;
    pkwrl_pkg::job_t                job;
    logic                           job_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= pkwrl_pkg::LIMIT_RESET;
            window_reg <= pkwrl_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pkwrl_pkg::REG_LIMIT:
                begin
                    limit_reg <= cfg_wdata[pkwrl_pkg::LIMIT_W-1:0];
                end
                pkwrl_pkg::REG_WINDOW:
                begin
                    window_reg <= cfg_wdata[pkwrl_pkg::WINDOW_W-1:0];
                end
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    pkwrl_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .limit_per_window (limit_reg),
        .job_valid        (job_valid),
        .job              (job),
        .job_pop          (job_pop)
    );

    pkwrl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .limit_per_window (limit_reg),
        .window_seconds   (window_reg),
        .job_valid        (job_valid),
        .job              (job),
        .job_pop          (job_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

endmodule

// ===== rtl/pkwrl_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pkwrl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pkwrl_front.sv =====
// front end: accepts request beats, tags disabled ones, holds a two-deep queue
// depends on pkwrl_pkg
`timescale 1ns / 1ps

module pkwrl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pkwrl_pkg::in_t                in_data,
    input  logic [pkwrl_pkg::LIMIT_W-1:0] limit_per_window,
    output logic                          job_valid,
    output pkwrl_pkg::job_t               job,
    input  logic                          job_pop
);

    pkwrl_pkg::job_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            push;
    logic            pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign job_valid = (fill_reg != 2'd0);
    assign job       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_pop && job_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].item     <= in_data;
            slot_reg[wr_ptr_reg].disabled <= (limit_per_window == '0);
        end
    end

endmodule

// ===== rtl/pkwrl_back.sv =====
// back end: scans the key table one entry per cycle; updates hits, adds keys
// depends on pkwrl_pkg and pkwrl_ram
`timescale 1ns / 1ps

module pkwrl_back #(
    parameter int unsigned TABLE_ENTRIES = pkwrl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pkwrl_pkg::LIMIT_W-1:0]  limit_per_window,
    input  logic [pkwrl_pkg::WINDOW_W-1:0] window_seconds,
    input  logic                           job_valid,
    input  pkwrl_pkg::job_t                job,
    output logic                           job_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pkwrl_pkg::out_t                out_data
);

    localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_HIT  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    pkwrl_pkg::in_t                item_reg;
    pkwrl_pkg::in_t                item_next;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [USED_W-1:0]             used_reg;
    logic [USED_W-1:0]             used_next;
    pkwrl_pkg::entry_t             hit_reg;
    pkwrl_pkg::entry_t             hit_next;
    pkwrl_pkg::out_t               res_reg;
    pkwrl_pkg::out_t               res_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    pkwrl_pkg::out_t               out_data_reg;
    pkwrl_pkg::out_t               out_data_next;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    pkwrl_pkg::entry_t             ram_wdata;
    logic [IDX_W-1:0]              ram_raddr;
    pkwrl_pkg::entry_t             ram_rdata;
    logic [$bits(pkwrl_pkg::entry_t)-1:0] ram_rdata_raw;

    logic [pkwrl_pkg::TIME_W-1:0]  elapsed;
    logic                          live;
    logic                          room;
    logic [USED_W-1:0]             idx_plus_one;

    pkwrl_ram #(
        .WIDTH ($bits(pkwrl_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata    = pkwrl_pkg::entry_t'(ram_rdata_raw);
    assign elapsed      = item_reg.current_time - hit_reg.window_start;
    assign live         = (elapsed < {{(pkwrl_pkg::TIME_W - pkwrl_pkg::WINDOW_W){1'b0}},
                                      window_seconds});
    assign room         = (used_reg != USED_MAX);
    assign idx_plus_one = USED_W'(idx_reg) + USED_W'(1);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        job_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '{key: item_reg.user_key, window_start: item_reg.current_time,
                           count: pkwrl_pkg::LIMIT_W'(1)};
        ram_raddr      = idx_reg + IDX_W'(1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    item_next = job.item;
                    idx_next  = '0;
                    if (job.disabled)
                    begin
                        res_next   = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_DISABLED};
                        state_next = S_EMIT;
                    end
                    else if (used_reg == '0)
                    begin
                        // empty table, insert at entry zero
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = '{key: job.item.user_key,
                                       window_start: job.item.current_time,
                                       count: pkwrl_pkg::LIMIT_W'(1)};
                        used_next  = used_reg + USED_W'(1);
                        res_next   = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_NEW};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (ram_rdata.key == item_reg.user_key)
                begin
                    hit_next   = ram_rdata;
                    state_next = S_HIT;
                end
                else if (idx_plus_one == used_reg)
                begin
                    if (room)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = used_reg[IDX_W-1:0];
                        used_next = used_reg + USED_W'(1);
                        res_next  = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_NEW};
                    end
                    else
                    begin
                        res_next  = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_FULL};
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_HIT:
            begin
                if (!live)
                begin
                    ram_we   = 1'b1;
                    res_next = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_RESTART};
                end
                else if (hit_reg.count >= limit_per_window)
                begin
                    res_next = '{allowed: 1'b0, outcome: pkwrl_pkg::OUT_OVER};
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{key: hit_reg.key, window_start: hit_reg.window_start,
                                  count: hit_reg.count + pkwrl_pkg::LIMIT_W'(1)};
                    res_next  = '{allowed: 1'b1, outcome: pkwrl_pkg::OUT_COUNTED};
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== tb/sv/per_key_window_rate_limiter_top_tb.sv =====
// testbench for per_key_window_rate_limiter_top: directed, table-full and random request tests
// keeps its own copy of the key table to predict each decision beat; depends on pkwrl_pkg and the top module
`timescale 1ns / 1ps

module per_key_window_rate_limiter_top_tb;

    import pkwrl_pkg::*;

    localparam int unsigned NUM_ENTRIES = TABLE_ENTRIES_DEFAULT;
    localparam int unsigned POOL_SIZE   = 160;
    localparam int unsigned HOT_KEYS    = 24;
    localparam int unsigned SEG_ITEMS   = 108;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [LIMIT_W-1:0]  limit_reg = LIMIT_RESET;
    logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;
    logic [KEY_W-1:0]    tbl_key   [NUM_ENTRIES];
    logic [TIME_W-1:0]   tbl_start [NUM_ENTRIES];
    logic [LIMIT_W-1:0]  tbl_count [NUM_ENTRIES];
    int unsigned         used_entries = 0;

    out_t               expected_decisions[$];
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    logic [TIME_W-1:0]  epoch_s = '0;
    int unsigned        burst_left = 0;
    int unsigned        run_left = 0;
    int unsigned        stall_left = 0;
    int unsigned        errors = 0;
    int unsigned        cycles = 0;

    per_key_window_rate_limiter_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (run_left > 0)
        begin
            run_left <= run_left - 1;
            out_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            case ($urandom_range(0, 3))
                0:
                begin
                    run_left <= $urandom_range(50, 400);
                    stall_left <= 0;
                end
                1:
                begin
                    run_left <= $urandom_range(0, 3);
                    stall_left <= $urandom_range(1, 3);
                end
                2:
                begin
                    run_left <= $urandom_range(5, 30);
                    stall_left <= $urandom_range(20, 60);
                end
                default:
                begin
                    run_left <= 1;
                    stall_left <= 1;
                end
            endcase
        end
    end

    // decision beat checker
    always @(posedge clk)
    begin
        out_t exp_beat;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("decision beat with no request pending: allowed %0b, outcome %0d",
                       out_data.allowed, out_data.outcome);
                errors++;
            end
            else
            begin
                exp_beat = expected_decisions.pop_front();
                if (out_data.allowed !== exp_beat.allowed)
                begin
                    $error("allowed mismatch: expected %0b, actual %0b",
                           exp_beat.allowed, out_data.allowed);
                    errors++;
                end
                if (out_data.outcome !== exp_beat.outcome)
                begin
                    $error("outcome mismatch: expected %0d, actual %0d",
                           exp_beat.outcome, out_data.outcome);
                    errors++;
                end
            end
        end
    end

    function automatic out_t decide_request(in_t req);
        out_t        res;
        logic [31:0] elapsed;
        int          hit;
        hit = -1;
        res.allowed = 1'b1;
        res.outcome = OUT_DISABLED;
        if (limit_reg == '0)
            return res;
        for (int i = 0; i < used_entries; i++)
        begin
            if (tbl_key[i] == req.user_key)
            begin
                hit = i;
                break;
            end
        end
        if (hit >= 0)
        begin
            elapsed = req.current_time - tbl_start[hit];
            if (elapsed < {16'b0, window_reg})
            begin
                if (tbl_count[hit] >= limit_reg)
                begin
                    res.allowed = 1'b0;
                    res.outcome = OUT_OVER;
                end
                else
                begin
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
                    res.outcome = OUT_COUNTED;
                end
            end
            else
            begin
                tbl_count[hit] = LIMIT_W'(1);
                tbl_start[hit] = req.current_time;
                res.outcome = OUT_RESTART;
            end
        end
        else if (used_entries < NUM_ENTRIES)
        begin
            tbl_key[used_entries] = req.user_key;
            tbl_start[used_entries] = req.current_time;
            tbl_count[used_entries] = LIMIT_W'(1);
            used_entries++;
            res.outcome = OUT_NEW;
        end
        else
            res.outcome = OUT_FULL;
        return res;
    endfunction

    task automatic hold_off(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_request(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] t);
        in_t req;
        req.user_key = key;
        req.current_time = t;
        if (burst_left == 0)
        begin
            hold_off(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_decisions.push_back(decide_request(req));
    endtask

    task automatic drain_results();
        hold_off(1);
        while (expected_decisions.size() != 0)
            @(posedge clk);
        hold_off(2);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LIMIT)
            limit_reg = data[LIMIT_W-1:0];
        else
            window_reg = data[WINDOW_W-1:0];
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] lim_word,
                                  input logic [CFG_DATA_W-1:0] win_word);
        drain_results();
        write_register(REG_LIMIT, lim_word);
        write_register(REG_WINDOW, win_word);
    endtask

    task automatic send_random_request();
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] t;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            key = key_pool[$urandom_range(0, HOT_KEYS - 1)];
        else if (pick < 93)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            key = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 70)
            epoch_s += $urandom_range(0, 3);
        else if (pick < 90)
            epoch_s += $urandom_range(0, 200);
        else if (pick < 96)
            epoch_s = $urandom;
        t = epoch_s;
        if (pick >= 96)
            t = epoch_s - $urandom_range(1, 50);
        send_request(key, t);
    endtask

    task automatic run_segment(input logic [CFG_DATA_W-1:0] lim_word,
                               input logic [CFG_DATA_W-1:0] win_word);
        apply_settings(lim_word, win_word);
        repeat (SEG_ITEMS)
            send_random_request();
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
        k0 = '0;
        k1 = '1;
        // reset settings: limit 60, window 60
        send_request(k0, 32'd0);
        send_request(k1, 32'hFFFF_FFFF);
        send_request(k0, 32'd59);
        send_request(k1, 32'd58);
        send_request(k0, 32'd60);
        send_request(k1, 32'd59);
        apply_settings(16'd2, 16'hFFFF);
        send_request(k0, 32'd61);
        send_request(k0, 32'd62);
        send_request(k0, 32'd65595);
        send_request(k0, 32'd65596);
        send_request(k0, 32'd65597);
        // limit lowered below stored count
        apply_settings(16'd1, 16'hFFFF);
        send_request(k0, 32'd65598);
        // zero window restarts every hit
        apply_settings(16'd1, 16'd0);
        send_request(k0, 32'd65599);
        send_request(k1, 32'd0);
        // limiting disabled, upper data bits set
        apply_settings(16'hFC00, 16'd60);
        send_request(k0, 32'd70);
        send_request(64'h5555_5555_5555_5555, 32'd7);
        apply_settings(16'h03FF, 16'd1);
        send_request(k0, 32'd100);
        send_request(k0, 32'd100);
        send_request(k0, 32'd101);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000);
    endtask

    task automatic test_random_early();
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: run_segment(16'd3, 16'd10);
                1: run_segment(16'd1, 16'd4);
                2: run_segment(16'd2, 16'd0);
                3: run_segment(16'h03FF, 16'hFFFF);
                4: run_segment({6'($urandom_range(0, 63)), 10'($urandom_range(1, 8))},
                               16'($urandom_range(1, 30)));
                default: run_segment(16'd0, 16'd30);
            endcase
        end
    endtask

    task automatic test_table_full();
        apply_settings(16'd4, 16'd100);
        while (used_entries < NUM_ENTRIES)
            send_random_request_fresh();
        repeat (10)
            send_request({$urandom, $urandom}, epoch_s);
        repeat (10)
            send_request(tbl_key[$urandom_range(0, NUM_ENTRIES - 1)],
                         epoch_s + $urandom_range(0, 150));
    endtask

    task automatic send_random_request_fresh();
        epoch_s += $urandom_range(0, 2);
        send_request({$urandom, $urandom}, epoch_s);
    endtask

    task automatic test_random_late();
        epoch_s = 32'hFFFF_F000;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: run_segment(16'd5, 16'd20);
                1: run_segment(16'd1, 16'd1);
                2: run_segment(16'($urandom), 16'($urandom));
                3: run_segment(16'd4, 16'd3);
                4: run_segment(16'd2, 16'd100);
                default: run_segment(16'd60, 16'd60);
            endcase
        end
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_early();
        test_table_full();
        test_random_late();
        drain_results();
        repeat (20)
            @(posedge clk);
        if (errors == 0 && expected_decisions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
